// ===== rtl/mitau_pkg.sv =====
// Shared types and codes for the MPLS/IPv4 TTL action unit.
`default_nettype none

package mitau_pkg;

   typedef enum logic [2:0] {
      ACT_SET_MPLS_TTL = 3'd0,
      ACT_DEC_MPLS_TTL = 3'd1,
      ACT_COPY_OUT     = 3'd2,
      ACT_COPY_IN      = 3'd3,
      ACT_SET_IP_TTL   = 3'd4,
      ACT_DEC_IP_TTL   = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NO_MPLS = 2'd1,
      STAT_NO_IPV4 = 2'd2,
      STAT_NO_ROOM = 2'd3
   } status_type;

   localparam int unsigned TTL_W   = 8;
   localparam int unsigned LABEL_W = 32;
   localparam int unsigned CSUM_W  = 16;
   localparam int unsigned S_BIT   = 8;

   typedef struct packed {
      logic [2:0]         req_type;
      logic               has_mpls;
      logic               has_ipv4;
      logic               room_for_ipv4;
      logic [LABEL_W-1:0] outer_label_word;
      logic [LABEL_W-1:0] inner_label_word;
      logic [TTL_W-1:0]   ip_ttl_in;
      logic [TTL_W-1:0]   ip_protocol;
      logic [CSUM_W-1:0]  ip_checksum_in;
      logic [TTL_W-1:0]   ttl_value;
   } req_type_type;

   typedef struct packed {
      logic [LABEL_W-1:0] outer_label_out;
      logic [LABEL_W-1:0] inner_label_out;
      logic [TTL_W-1:0]   ip_ttl_out;
      logic [CSUM_W-1:0]  ip_checksum_out;
      logic [1:0]         action_status;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/mitau_ifs.sv =====
// Valid/ready channel interfaces for the TTL action unit request and response.
`default_nettype none

interface mitau_req_if
   import mitau_pkg::*;
();
   logic         valid;
   logic         ready;
   req_type_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mitau_rsp_if
   import mitau_pkg::*;
();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/mpls_ipv4_ttl_action_unit.sv =====
// Top level: applies one MPLS or IPv4 TTL action per request, two-register pipeline.
//
// Usage:
//   req_chan carries one action request per transfer: the action code, header
//   presence flags and the already parsed MPLS words and IPv4 TTL/protocol/
//   checksum. rsp_chan returns exactly one result per request, in order: the
//   rewritten label words, IPv4 TTL, incrementally updated checksum
//   (RFC 1624) and a status code.
//   Path: a transferred request is written into the input register, then
//   the action logic feeds the response register, whose output drives
//   rsp_chan.valid and the response payload.
//   Throughput: one request per cycle, sustained, as long as rsp_chan takes
//   one response per cycle; the action logic is a single pass between the two
//   registers with no state carried from one request to the next.
//   Stall: when rsp_chan.ready is low the response register holds; the input
//   register still takes one more request, then req_chan.ready drops until
//   the response is taken.
//   Reset (synchronous, active high): both pipeline stages are emptied;
//   nothing else is held, so the unit is ready the cycle after reset.
`default_nettype none

module mpls_ipv4_ttl_action_unit
   import mitau_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   mitau_req_if.sink        req_chan,
   mitau_rsp_if.source      rsp_chan
);

   // stage 1: captured request
   logic         s1_valid_ff, s1_valid_in;
   req_type_type s1_data_ff;

   // stage 2: response register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   logic req_xfer;
   logic s2_load;

   assign s2_load        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s2_load;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s2_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_data_ff <= req_chan.payload;
      end
      if (s2_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------- action logic ----------------
   logic [TTL_W-1:0]   outer_ttl;
   logic [TTL_W-1:0]   ip_ttl_new;
   logic               ip_write;
   logic               s_bit;
   logic [CSUM_W-1:0]  old_word;
   logic [CSUM_W-1:0]  new_word;
   logic [CSUM_W+1:0]  csum_sum;
   logic [CSUM_W:0]    csum_fold1;
   logic [CSUM_W-1:0]  csum_fold2;
   logic [CSUM_W-1:0]  csum_new;
   status_type         status;

   assign outer_ttl = s1_data_ff.outer_label_word[TTL_W-1:0];
   assign s_bit     = s1_data_ff.outer_label_word[S_BIT];

   // RFC 1624 eqn 3 over the word {ttl, protocol}
   assign old_word   = {s1_data_ff.ip_ttl_in, s1_data_ff.ip_protocol};
   assign new_word   = {ip_ttl_new, s1_data_ff.ip_protocol};
   assign csum_sum   = {2'b00, ~s1_data_ff.ip_checksum_in} + {2'b00, ~old_word}
                       + {2'b00, new_word};
   assign csum_fold1 = {1'b0, csum_sum[CSUM_W-1:0]} + {{(CSUM_W-1){1'b0}},
                       csum_sum[CSUM_W+1:CSUM_W]};
   assign csum_fold2 = csum_fold1[CSUM_W-1:0] + {{(CSUM_W-1){1'b0}}, csum_fold1[CSUM_W]};
   assign csum_new   = ~csum_fold2;

   always_comb begin
      rsp_data_in.outer_label_out = s1_data_ff.outer_label_word;
      rsp_data_in.inner_label_out = s1_data_ff.inner_label_word;
      ip_ttl_new                  = s1_data_ff.ip_ttl_in;
      ip_write                    = 1'b0;
      status                      = STAT_OK;

      case (action_type'(s1_data_ff.req_type))
         ACT_SET_MPLS_TTL: begin
            if (!s1_data_ff.has_mpls) begin
               status = STAT_NO_MPLS;
            end else begin
               rsp_data_in.outer_label_out[TTL_W-1:0] = s1_data_ff.ttl_value;
            end
         end
         ACT_DEC_MPLS_TTL: begin
            if (!s1_data_ff.has_mpls) begin
               status = STAT_NO_MPLS;
            end else if (outer_ttl != '0) begin
               rsp_data_in.outer_label_out[TTL_W-1:0] = outer_ttl - TTL_W'(1);
            end
         end
         ACT_COPY_OUT: begin
            if (!s1_data_ff.has_mpls) begin
               status = STAT_NO_MPLS;
            end else if (!s_bit) begin
               rsp_data_in.outer_label_out[TTL_W-1:0] =
                  s1_data_ff.inner_label_word[TTL_W-1:0];
            end else if (s1_data_ff.room_for_ipv4) begin
               rsp_data_in.outer_label_out[TTL_W-1:0] = s1_data_ff.ip_ttl_in;
            end else begin
               status = STAT_NO_ROOM;
            end
         end
         ACT_COPY_IN: begin
            if (!s1_data_ff.has_mpls) begin
               status = STAT_NO_MPLS;
            end else if (!s_bit) begin
               rsp_data_in.inner_label_out[TTL_W-1:0] = outer_ttl;
            end else if (s1_data_ff.room_for_ipv4) begin
               ip_ttl_new = outer_ttl;
               ip_write   = 1'b1;
            end else begin
               status = STAT_NO_ROOM;
            end
         end
         ACT_SET_IP_TTL: begin
            if (!s1_data_ff.has_ipv4) begin
               status = STAT_NO_IPV4;
            end else begin
               ip_ttl_new = s1_data_ff.ttl_value;
               ip_write   = 1'b1;
            end
         end
         ACT_DEC_IP_TTL: begin
            if (!s1_data_ff.has_ipv4) begin
               status = STAT_NO_IPV4;
            end else if (s1_data_ff.ip_ttl_in != '0) begin
               // checksum left alone when the TTL is already zero
               ip_ttl_new = s1_data_ff.ip_ttl_in - TTL_W'(1);
               ip_write   = 1'b1;
            end
         end
         default: begin
         end
      endcase

      rsp_data_in.ip_ttl_out      = ip_write ? ip_ttl_new : s1_data_ff.ip_ttl_in;
      rsp_data_in.ip_checksum_out = ip_write ? csum_new : s1_data_ff.ip_checksum_in;
      rsp_data_in.action_status   = status;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

`default_nettype wire
